// ----- hdl/oale_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Sizes, command and status codes, and the list store access bundle.
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_FIND       = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ----- hdl/oale_ram.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine store
// One write port and one registered read port over the list entries.
// ----------------------------------------------------------------------------
module oale_ram (
    input  logic                      aclk,
    input  oale_pkg::ram_req_t        req,
    output logic [oale_pkg::DATA_W-1:0] rdata
);
    import oale_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ----- hdl/ordered_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity ordered list of signed 32-bit values with push, pop,
// insert, erase, find and clear commands.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the s_ channel (s_cmd, s_position,
// s_value) and one result item leaves on the m_ channel (m_status,
// m_found_position, m_entry_total). s_ready is high only while the
// sequencer is idle; one command is worked on at a time.
// Errors, clear and pop back go straight to the final state; appends first
// write the entry. Inserts and removals walk the entries behind the position
// through the store, one entry per cycle; find walks from the front, one
// entry per cycle, and stops at the first match.
// Reset (aresetn low, synchronous) empties the list at once; entry contents
// are not cleared and are never read past the count.
// A stalled receiver holds the result register; the next command is still
// taken and worked on, and its result waits in the final state until the
// result register is free.
// ----------------------------------------------------------------------------
module ordered_array_list_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_cmd,
    input  logic [oale_pkg::CNT_W-1:0]   s_position,
    input  logic signed [oale_pkg::DATA_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [oale_pkg::CNT_W-1:0]   m_found_position,
    output logic [oale_pkg::CNT_W-1:0]   m_entry_total
);
    import oale_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_UP        = 9'b000000010,
        S_UP_TAIL   = 9'b000000100,
        S_PUT       = 9'b000001000,
        S_DN        = 9'b000010000,
        S_DN_TAIL   = 9'b000100000,
        S_FIND      = 9'b001000000,
        S_FIND_TAIL = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] lim_reg, lim_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [DATA_W-1:0] val_reg, val_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [CNT_W-1:0]  m_found_reg, m_found_next;
    logic [CNT_W-1:0]  m_total_reg, m_total_next;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    cmd_t              cmd_in;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_p1;
    logic [CNT_W-1:0]  pos_m1;
    logic [ADDR_W-1:0] last_idx;
    logic [ADDR_W-1:0] ins_idx;
    logic [ADDR_W-1:0] rm_idx;
    logic              is_full;
    logic              is_empty;
    logic              hit;
    logic              out_free;

    oale_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign cmd_in   = cmd_t'(s_cmd);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_p1   = count_reg + CNT_W'(1);
    assign pos_m1   = s_position - CNT_W'(1);
    assign last_idx = cnt_m1[ADDR_W-1:0];
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign hit      = (ram_rdata == val_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_entry_total    = m_total_reg;

    always_comb begin
        ins_idx = '0;
        rm_idx  = '0;
        unique case (cmd_in) inside
            CMD_PUSH_BACK: ins_idx = count_reg[ADDR_W-1:0];
            CMD_INSERT:    ins_idx = pos_m1[ADDR_W-1:0];
            default:       ins_idx = '0;
        endcase
        unique case (cmd_in) inside
            CMD_POP_BACK: rm_idx = last_idx;
            CMD_ERASE:    rm_idx = pos_m1[ADDR_W-1:0];
            default:      rm_idx = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        src_next      = src_reg;
        lim_next      = lim_reg;
        idx_next      = idx_reg;
        wr_addr_next  = wr_addr_reg;
        rd_pend_next  = rd_pend_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_total_next  = m_total_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = wr_addr_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = src_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next     = s_value;
                    status_next  = ST_OK;
                    found_next   = '0;
                    rd_pend_next = 1'b0;
                    state_next   = S_DONE;
                    unique case (cmd_in) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else if (cmd_in == CMD_INSERT &&
                                         (s_position == '0 || s_position > cnt_p1)) begin
                                status_next = ST_RANGE;
                            end else begin
                                idx_next = ins_idx;
                                if (CNT_W'(ins_idx) == count_reg) begin
                                    state_next = S_PUT;
                                end else begin
                                    src_next   = last_idx;
                                    lim_next   = ins_idx;
                                    state_next = S_UP;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if (cmd_in == CMD_ERASE &&
                                         (s_position == '0 || s_position > count_reg)) begin
                                status_next = ST_RANGE;
                            end else if (rm_idx == last_idx) begin
                                count_next = cnt_m1;
                            end else begin
                                src_next   = rm_idx + ADDR_W'(1);
                                lim_next   = last_idx;
                                state_next = S_DN;
                            end
                        end
                        CMD_FIND: begin
                            if (!is_empty) begin
                                src_next   = '0;
                                lim_next   = last_idx;
                                state_next = S_FIND;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                ram_req.we   = rd_pend_reg;
                wr_addr_next = src_reg + ADDR_W'(1);
                rd_pend_next = 1'b1;
                if (src_reg == lim_reg) begin
                    state_next = S_UP_TAIL;
                end else begin
                    src_next = src_reg - ADDR_W'(1);
                end
            end
            S_UP_TAIL: begin
                ram_req.we = 1'b1;
                state_next = S_PUT;
            end
            S_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = val_reg;
                count_next    = cnt_p1;
                state_next    = S_DONE;
            end
            S_DN: begin
                ram_req.we   = rd_pend_reg;
                wr_addr_next = src_reg - ADDR_W'(1);
                rd_pend_next = 1'b1;
                if (src_reg == lim_reg) begin
                    state_next = S_DN_TAIL;
                end else begin
                    src_next = src_reg + ADDR_W'(1);
                end
            end
            S_DN_TAIL: begin
                ram_req.we = 1'b1;
                count_next = cnt_m1;
                state_next = S_DONE;
            end
            S_FIND: begin
                wr_addr_next = src_reg;
                rd_pend_next = 1'b1;
                if (rd_pend_reg && hit) begin
                    found_next = CNT_W'(wr_addr_reg) + CNT_W'(1);
                    state_next = S_DONE;
                end else if (src_reg == lim_reg) begin
                    state_next = S_FIND_TAIL;
                end else begin
                    src_next = src_reg + ADDR_W'(1);
                end
            end
            S_FIND_TAIL: begin
                if (hit) begin
                    found_next = CNT_W'(wr_addr_reg) + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = found_reg;
                    m_total_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        lim_reg      <= lim_next;
        idx_reg      <= idx_next;
        wr_addr_reg  <= wr_addr_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_total_reg  <= m_total_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished command not loaded into result register");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg != '0) |-> (m_found_reg <= m_total_reg))
        else $error("found position beyond entry total");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cmd_in == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries in the list");

    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg != ST_OK) |-> $stable(count_reg))
        else $error("failed command changed the entry count");

endmodule

// ----- bench/list_result_checker.sv -----
// ----------------------------------------------------------------------------
// Ordered list result checker
// Watches both channels of the list engine. Keeps its own copy of the list,
// works out the result of every accepted command item, and compares each
// result item in order, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module list_result_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [2:0]                         s_cmd,
    input  logic [oale_pkg::CNT_W-1:0]         s_position,
    input  logic signed [oale_pkg::DATA_W-1:0] s_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [1:0]                         m_status,
    input  logic [oale_pkg::CNT_W-1:0]         m_found_position,
    input  logic [oale_pkg::CNT_W-1:0]         m_entry_total,
    output int                                 fail_count,
    output int                                 outstanding
);
    import oale_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] found;
        logic [CNT_W-1:0] total;
    } list_result_t;

    logic [DATA_W-1:0] entries [0:DEPTH-1];
    int                held;
    list_result_t      expected_results [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
        held        = 0;
    end

    function automatic list_result_t apply_command(input cmd_t c, input int p,
                                                   input logic [DATA_W-1:0] v);
        list_result_t r;
        int           slot;
        int           k;
        r.status = ST_OK;
        r.found  = '0;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (c == CMD_INSERT && (p < 1 || p > held + 1)) begin
                    r.status = ST_RANGE;
                end else begin
                    slot = (c == CMD_PUSH_FRONT) ? 0 : (c == CMD_PUSH_BACK) ? held : p - 1;
                    for (k = held; k > slot; k--)
                        entries[k] = entries[k-1];
                    entries[slot] = v;
                    held++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (c == CMD_ERASE && (p < 1 || p > held)) begin
                    r.status = ST_RANGE;
                end else begin
                    slot = (c == CMD_POP_FRONT) ? 0 : (c == CMD_POP_BACK) ? held - 1 : p - 1;
                    for (k = slot; k + 1 < held; k++)
                        entries[k] = entries[k+1];
                    held--;
                end
            end
            CMD_FIND: begin
                for (k = 0; k < held; k++)
                    if (r.found == 0 && entries[k] == v)
                        r.found = CNT_W'(k + 1);
            end
            CMD_CLEAR: begin
                held = 0;
            end
        endcase
        r.total = held[CNT_W-1:0];
        return r;
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        list_result_t want;
        if (!aresetn) begin
            held = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item: status %0d found %0d total %0d",
                             $time, m_status, m_found_position, m_entry_total);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report("status", want.status, m_status);
                    if (m_found_position !== want.found)
                        report("found_position", want.found, m_found_position);
                    if (m_entry_total !== want.total)
                        report("entry_total", want.total, m_entry_total);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_command(cmd_t'(s_cmd), int'(s_position),
                                                         s_value));
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Drives command items into the list engine: a directed pass over the error
// cases and field extremes, then random runs that fill, drain and mix the
// list under several idle and stall patterns. The checker beside the engine
// predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import oale_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 350;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } mix_t;

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_cmd            = CMD_FIND;
    logic [CNT_W-1:0]         s_position       = '0;
    logic signed [DATA_W-1:0] s_value          = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic [1:0]               m_status;
    logic [CNT_W-1:0]         m_found_position;
    logic [CNT_W-1:0]         m_entry_total;

    int fail_count;
    int outstanding;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int tracked_total  = 0;
    int idle_cycles    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ordered_array_list_engine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_entry_total    (m_entry_total)
    );

    list_result_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_entry_total    (m_entry_total),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic issue_command(input cmd_t c, input int p, input logic [DATA_W-1:0] v);
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
                if (tracked_total < DEPTH) tracked_total++;
            CMD_INSERT:
                if (tracked_total < DEPTH && p >= 1 && p <= tracked_total + 1) tracked_total++;
            CMD_POP_FRONT, CMD_POP_BACK:
                if (tracked_total > 0) tracked_total--;
            CMD_ERASE:
                if (tracked_total > 0 && p >= 1 && p <= tracked_total) tracked_total--;
            CMD_CLEAR:
                tracked_total = 0;
            default: ;
        endcase
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= c;
        s_position <= p[CNT_W-1:0];
        s_value    <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic cmd_t pick_command(input mix_t mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW:
                return r < 25 ? CMD_PUSH_FRONT : r < 50 ? CMD_PUSH_BACK :
                       r < 75 ? CMD_INSERT     : r < 82 ? CMD_POP_FRONT :
                       r < 86 ? CMD_POP_BACK   : r < 90 ? CMD_ERASE :
                       r < 99 ? CMD_FIND       : CMD_CLEAR;
            MIX_SHRINK:
                return r < 5  ? CMD_PUSH_FRONT : r < 10 ? CMD_PUSH_BACK :
                       r < 15 ? CMD_INSERT     : r < 35 ? CMD_POP_FRONT :
                       r < 55 ? CMD_POP_BACK   : r < 80 ? CMD_ERASE :
                       r < 98 ? CMD_FIND       : CMD_CLEAR;
            default:
                return r < 98 ? cmd_t'(r % 7) : CMD_CLEAR;
        endcase
    endfunction

    function automatic int pick_position(input cmd_t c);
        if ($urandom_range(9) == 0)
            return $urandom_range(63);
        case (c)
            CMD_INSERT: return $urandom_range(tracked_total + 1, 1);
            CMD_ERASE:  return tracked_total == 0 ? 1 : $urandom_range(tracked_total, 1);
            default:    return $urandom_range(63);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(15);
        if (r < 70)
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        return $urandom;
    endfunction

    task automatic run_random_commands(input int count);
        mix_t mix;
        int   left;
        cmd_t c;
        left = 0;
        mix  = MIX_ANY;
        repeat (count) begin
            if (left == 0) begin
                mix  = mix_t'($urandom_range(2));
                left = $urandom_range(48, 16);
            end
            left--;
            c = pick_command(mix);
            issue_command(c, pick_position(c), pick_value());
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list
        issue_command(CMD_FIND,       0,  32'h0000_0000);
        issue_command(CMD_POP_FRONT,  0,  32'h0000_0000);
        issue_command(CMD_POP_BACK,   0,  32'h0000_0000);
        issue_command(CMD_ERASE,      1,  32'h0000_0000);
        issue_command(CMD_INSERT,     0,  32'h0000_0001);
        issue_command(CMD_INSERT,     2,  32'h0000_0001);
        // build a short list
        issue_command(CMD_INSERT,     1,  32'h1234_5678);
        issue_command(CMD_PUSH_FRONT, 0,  32'h8000_0000);
        issue_command(CMD_PUSH_BACK,  0,  32'h7FFF_FFFF);
        issue_command(CMD_PUSH_BACK,  63, 32'hFFFF_FFFF);
        issue_command(CMD_INSERT,     5,  32'h0000_0000);
        issue_command(CMD_INSERT,     3,  32'hAAAA_AAAA);
        // bad positions
        issue_command(CMD_ERASE,      0,  32'h0000_0000);
        issue_command(CMD_ERASE,      7,  32'h0000_0000);
        issue_command(CMD_ERASE,      63, 32'h0000_0000);
        issue_command(CMD_INSERT,     63, 32'h5555_5555);
        // lookups
        issue_command(CMD_FIND,       0,  32'h7FFF_FFFF);
        issue_command(CMD_FIND,       0,  32'hFFFF_FFFF);
        issue_command(CMD_FIND,       0,  32'h5555_5555);
        // removals
        issue_command(CMD_POP_FRONT,  0,  32'h0000_0000);
        issue_command(CMD_POP_BACK,   0,  32'h0000_0000);
        issue_command(CMD_ERASE,      2,  32'h0000_0000);
        issue_command(CMD_ERASE,      3,  32'h0000_0000);
        issue_command(CMD_CLEAR,      0,  32'h0000_0000);
        issue_command(CMD_POP_BACK,   0,  32'h0000_0000);

        idle_pct = 0;  stall_pct = 0;  run_random_commands(PHASE_ITEMS);
        idle_pct = 47; stall_pct = 0;  run_random_commands(PHASE_ITEMS);
        idle_pct = 0;  stall_pct = 47; run_random_commands(PHASE_ITEMS);
        idle_pct = 27; stall_pct = 27; run_random_commands(PHASE_ITEMS);
        s_valid <= 1'b0;
        @(posedge aclk);

        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/oale_pkg.sv
hdl/oale_ram.sv
hdl/ordered_array_list_engine.sv
bench/list_result_checker.sv
bench/tb_top.sv
